/* rtl/core/sdes_pkg.sv */
// Shared S-DES definitions: register indexes, permutations and S-boxes.
// No dependencies; imported by every module of the byte cipher.
package sdes_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int KEY_W     = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY  = 2'd0,
		CFG_IV   = 2'd1,
		CFG_MODE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] k1;
		logic [7:0] k2;
	} subkeys_t;

	localparam logic [1:0] SBOX0 [4][4] = '{
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd3, 2'd1, 2'd3, 2'd2}
	};

	localparam logic [1:0] SBOX1 [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd0},
		'{2'd2, 2'd1, 2'd0, 2'd3}
	};

	function automatic logic [9:0] p10(input logic [9:0] k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic logic [7:0] p8(input logic [9:0] v);
		return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
	endfunction

	function automatic logic [7:0] ip(input logic [7:0] x);
		return {x[6], x[2], x[5], x[7], x[4], x[0], x[3], x[1]};
	endfunction

	function automatic logic [7:0] ip_inv(input logic [7:0] y);
		return {y[4], y[7], y[5], y[3], y[1], y[6], y[0], y[2]};
	endfunction

	function automatic logic [7:0] ep(input logic [3:0] n);
		return {n[0], n[3], n[2], n[1], n[2], n[1], n[0], n[3]};
	endfunction

	function automatic logic [3:0] p4(input logic [3:0] s);
		return {s[2], s[0], s[1], s[3]};
	endfunction

	function automatic logic [4:0] rotl1(input logic [4:0] h);
		return {h[3:0], h[4]};
	endfunction

	function automatic logic [4:0] rotl3(input logic [4:0] h);
		return {h[1:0], h[4:2]};
	endfunction

endpackage

/* rtl/core/sdes_key_sched.sv */
// Key schedule: derives K1 and K2 from a key write and holds them.
// Depends on sdes_pkg.
module sdes_key_sched
	import sdes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_we,
	input  logic [KEY_W-1:0] key_data,
	output subkeys_t         subkeys
);

	logic [9:0] perm;
	logic [4:0] lh;
	logic [4:0] rh;
	subkeys_t   subkeys_q;

	always_comb begin
		perm = p10(key_data);
		lh   = perm[9:5];
		rh   = perm[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkeys_q <= '0;
		end else if (key_we) begin
			subkeys_q.k1 <= p8({rotl1(lh), rotl1(rh)});
			subkeys_q.k2 <= p8({rotl3(lh), rotl3(rh)});
		end
	end

	assign subkeys = subkeys_q;

endmodule

/* rtl/core/sdes_fk.sv */
// One S-DES round function fk: expansion, key mix, S-boxes, P4.
// Depends on sdes_pkg.
module sdes_fk
	import sdes_pkg::*;
(
	input  logic [7:0] x,
	input  logic [7:0] subkey,
	output logic [7:0] y
);

	logic [7:0] e;
	logic [3:0] s;

	always_comb begin
		e = ep(x[3:0]) ^ subkey;
		s = {SBOX0[{e[7], e[4]}][{e[6], e[5]}], SBOX1[{e[3], e[0]}][{e[2], e[1]}]};
		y = {x[7:4] ^ p4(s), x[3:0]};
	end

endmodule

/* rtl/core/sdes_block.sv */
// S-DES block on one byte: IP, fk, nibble swap, fk, inverse IP.
// Depends on sdes_pkg and sdes_fk.
module sdes_block
	import sdes_pkg::*;
(
	input  logic [7:0] din,
	input  logic [7:0] key_a,
	input  logic [7:0] key_b,
	output logic [7:0] dout
);

	logic [7:0] r1_in;
	logic [7:0] r1_out;
	logic [7:0] r2_in;
	logic [7:0] r2_out;

	assign r1_in = ip(din);

	sdes_fk u_fk1 (
		.x      (r1_in),
		.subkey (key_a),
		.y      (r1_out)
	);

	assign r2_in = {r1_out[3:0], r1_out[7:4]};

	sdes_fk u_fk2 (
		.x      (r2_in),
		.subkey (key_b),
		.y      (r2_out)
	);

	assign dout = ip_inv(r2_out);

endmodule

/* rtl/core/sdes_cbc_byte_cipher.sv */
// Top level of the S-DES CBC byte cipher: input stage, cipher, result register.
// Depends on sdes_pkg, sdes_key_sched and sdes_block.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------
//  in      | in_valid, in_ready, data_byte,            | byte to cipher
//          | first_of_message                          |
//  out     | out_valid, out_ready, result_byte         | ciphered byte
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// One byte per cycle unless the output stalls; each result is registered.
// In encrypt mode the CBC chain loop closes through one S-DES block.
// Reset clears keys, IV, mode, chain value and all valid flags.
// Output stall holds the result; the input stage still takes one more byte.
module sdes_cbc_byte_cipher
	import sdes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 first_of_message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           result_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	subkeys_t   subkeys;
	logic       cfg_we;
	logic [7:0] iv_q;
	logic       mode_q;
	logic [7:0] chain_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       out_valid_q;
	logic [7:0] result_q;
	logic       adv_s1;
	logic [7:0] prev;
	logic [7:0] blk_in;
	logic [7:0] blk_out;
	logic [7:0] key_a;
	logic [7:0] key_b;
	logic [7:0] res;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	sdes_key_sched u_key_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_we   (cfg_we && (cfg_index == CFG_KEY)),
		.key_data (cfg_data),
		.subkeys  (subkeys)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q   <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IV) begin
				iv_q <= cfg_data[7:0];
			end
			if (cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first_of_message;
		end
	end

	always_comb begin
		prev   = first_s1 ? iv_q : chain_q;
		key_a  = mode_q ? subkeys.k2 : subkeys.k1;
		key_b  = mode_q ? subkeys.k1 : subkeys.k2;
		blk_in = mode_q ? data_s1 : (data_s1 ^ prev);
		res    = mode_q ? (blk_out ^ prev) : blk_out;
	end

	sdes_block u_block (
		.din   (blk_in),
		.key_a (key_a),
		.key_b (key_b),
		.dout  (blk_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chain_q     <= '0;
		end else begin
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				chain_q     <= mode_q ? data_s1 : res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

`ifndef ASSERT_OFF
	a_chain_enc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !mode_q) |=> (chain_q == result_q))
		else $error("chain value differs from ciphertext after encrypt");

	a_chain_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && mode_q) |=> (chain_q == $past(data_s1)))
		else $error("chain value differs from ciphertext input after decrypt");

	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(chain_q) |-> $past(adv_s1))
		else $error("chain value changed without a transaction");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result shown without an input stage transaction");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage refuses a transaction");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sdes_cbc_byte_cipher: CBC-chained S-DES, one byte per transaction.
// Needs only sdes_pkg and the RTL. Prediction is computed in-bench from typed bit tables.
module tb;
	import sdes_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	// bit positions counted from 1 at the MSB, first entry in the highest nibble in use
	localparam logic [39:0] POS_P10   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
		4'd8, 4'd6};
	localparam logic [39:0] POS_P8    = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10,
		4'd9};
	localparam logic [39:0] POS_IP    = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5,
		4'd7};
	localparam logic [39:0] POS_IPINV = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8,
		4'd6};
	localparam logic [39:0] POS_EP    = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4,
		4'd1};
	localparam logic [39:0] POS_P4    = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} cbc_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = 8'd0;
	logic                 first_of_message = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           result_byte;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY;
	logic [KEY_W-1:0]     cfg_data = '0;

	cbc_item_t  bytes_to_send [$];
	logic [7:0] expected_bytes [$];
	cbc_item_t  sent_item;
	logic       in_fire = 1'b0;
	int         send_idle = 32;
	int         recv_idle = 65;
	int         cycles = 0;
	int         err_count = 0;

	logic [9:0] key_reg = '0;
	logic [7:0] iv_reg = '0;
	logic       mode_reg = 1'b0;
	logic [7:0] chain_reg = '0;

	sdes_cbc_byte_cipher i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_byte      (result_byte),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [9:0] select_bits(input logic [9:0] v, input int w,
		input logic [39:0] pos, input int n);
		logic [9:0] r;
		int k;
		r = '0;
		for (int i = 0; i < n; i++) begin
			k = int'(pos[4*(n-1-i) +: 4]);
			r = {r[8:0], v[w-k]};
		end
		return r;
	endfunction

	function automatic logic [4:0] rotl5(input logic [4:0] h, input int r);
		logic [9:0] d;
		d = {h, h} << r;
		return d[9:5];
	endfunction

	function automatic logic [7:0] round_f(input logic [7:0] x, input logic [7:0] k);
		logic [9:0] t;
		logic [7:0] e;
		logic [3:0] s;
		t = select_bits({6'd0, x[3:0]}, 4, POS_EP, 8);
		e = t[7:0] ^ k;
		s = {SBOX0[{e[7], e[4]}][{e[6], e[5]}], SBOX1[{e[3], e[0]}][{e[2], e[1]}]};
		t = select_bits({6'd0, s}, 4, POS_P4, 4);
		return x ^ {t[3:0], 4'd0};
	endfunction

	function automatic logic [7:0] sdes_byte(input logic [7:0] x, input logic [7:0] ka,
		input logic [7:0] kb);
		logic [9:0] t;
		logic [7:0] y;
		t = select_bits({2'd0, x}, 8, POS_IP, 8);
		y = round_f(t[7:0], ka);
		y = round_f({y[3:0], y[7:4]}, kb);
		t = select_bits({2'd0, y}, 8, POS_IPINV, 8);
		return t[7:0];
	endfunction

	// advances the chain register, returns the byte the block should emit
	function automatic logic [7:0] cbc_step(input logic [7:0] data, input logic first);
		logic [9:0] p, t;
		logic [7:0] prev, k1, k2, res;
		prev = first ? iv_reg : chain_reg;
		p = select_bits(key_reg, 10, POS_P10, 10);
		t = select_bits({rotl5(p[9:5], 1), rotl5(p[4:0], 1)}, 10, POS_P8, 8);
		k1 = t[7:0];
		t = select_bits({rotl5(p[9:5], 3), rotl5(p[4:0], 3)}, 10, POS_P8, 8);
		k2 = t[7:0];
		if (mode_reg) begin
			res = sdes_byte(data, k2, k1) ^ prev;
			chain_reg = data;
		end else begin
			res = sdes_byte(data ^ prev, k1, k2);
			chain_reg = res;
		end
		return res;
	endfunction

	task automatic report_error(input string msg);
		$display("tb: error at cycle %0d: %s", cycles, msg);
		err_count++;
	endtask

	task automatic push_byte(input logic [7:0] data, input logic first);
		bytes_to_send.push_back(cbc_item_t'{data, first});
	endtask

	task automatic drain();
		while (bytes_to_send.size() != 0 || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
		drain();
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_KEY:  key_reg = val;
			CFG_IV:   iv_reg = val[7:0];
			CFG_MODE: mode_reg = val[0];
			default:  ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// monitor: prediction on input transactions, compare on output transactions
	always @(posedge clk) begin
		logic [7:0] exp_b;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			in_fire = in_valid && in_ready;
			if (in_fire)
				expected_bytes.push_back(cbc_step(data_byte, first_of_message));
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report_error($sformatf("result %02h with nothing outstanding", result_byte));
				end else begin
					exp_b = expected_bytes.pop_front();
					if (result_byte !== exp_b)
						report_error($sformatf("result_byte %02h, want %02h", result_byte, exp_b));
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (!in_valid || in_fire) begin
			if (in_fire)
				sent_item = bytes_to_send.pop_front();
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
				in_valid         <= 1'b1;
				data_byte        <= bytes_to_send[0].data;
				first_of_message <= bytes_to_send[0].first;
			end else begin
				in_valid         <= 1'b0;
				data_byte        <= 8'($urandom);
				first_of_message <= 1'($urandom);
			end
		end
	end

	initial begin
		int len;
		int n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no message start after reset: chain comes from the cleared register
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);

		write_reg(CFG_KEY, 10'h3FF);
		write_reg(CFG_IV, 10'h3FF);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);

		// unmapped index must be dropped
		write_reg(CFG_NONE, 10'h3FF);
		push_byte(8'h55, 1'b0);

		// key and IV changes mid-message keep the chain
		write_reg(CFG_KEY, 10'h282);
		push_byte(8'hAA, 1'b0);
		write_reg(CFG_IV, 10'h13C);
		push_byte(8'h12, 1'b0);
		push_byte(8'h12, 1'b1);

		write_reg(CFG_MODE, 10'h3FF);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7E, 1'b0);
		write_reg(CFG_KEY, 10'h000);
		write_reg(CFG_IV, 10'h000);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		write_reg(CFG_MODE, 10'h002);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);

		for (int seg = 0; seg < 12; seg++) begin
			send_idle = (seg < 4) ? 32 : (seg < 8) ? 65 : 0;
			recv_idle = (seg < 4) ? 65 : (seg < 8) ? 32 : 0;
			write_reg(CFG_KEY, (seg == 0) ? 10'h000 : (seg == 1) ? 10'h3FF : 10'($urandom));
			write_reg(CFG_IV, {2'($urandom),
				(seg == 0) ? 8'hFF : (seg == 1) ? 8'h00 : 8'($urandom)});
			write_reg(CFG_MODE, {9'($urandom), 1'(seg % 2)});
			if (seg == 5)
				write_reg(CFG_NONE, 10'($urandom));
			for (int half = 0; half < 2; half++) begin
				n = 0;
				while (n < 35) begin
					len = $urandom_range(1, 10);
					// mostly well-formed messages, some unmarked starts and stray restarts
					for (int j = 0; j < len; j++)
						push_byte(8'($urandom), (j == 0) ? ($urandom_range(9) != 0) :
							($urandom_range(19) == 0));
					n += len;
				end
				// sender holds off until the block has emptied
				drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
